// ===== design/fsgs_pkg.sv =====
`timescale 1ns / 1ps

package fsgs_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int ADDR_W    = COL_W + ROW_W;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SWEEP = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_SAND  = 2'd1;
  localparam logic [1:0] KIND_WATER = 2'd2;
  localparam logic [1:0] KIND_SMOKE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] kind_in;
  } fsgs_in_t;

  typedef struct packed {
    logic [1:0] kind_out;
    logic [1:0] done_func;
  } fsgs_out_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_IO,
    WR_TGT,
    WR_CTR
  } fsgs_wr_sel_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_IO,
    RD_CTR,
    RD_NB
  } fsgs_rd_sel_t;

  typedef struct packed {
    fsgs_wr_sel_t wr_sel;
    fsgs_rd_sel_t rd_sel;
    logic         item_ld;
    logic         kind_ld;
    logic         cand_inc;
    logic         adv;
    logic         clr_step;
    logic         out_ld;
    logic         out_from_in;
  } fsgs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic moves;
    logic nb_free;
    logic cand_last;
    logic sweep_last;
    logic out_free;
  } fsgs_sts_t;

endpackage

// ===== design/fsgs_dp.sv =====
`timescale 1ns / 1ps

module fsgs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fsgs_pkg::fsgs_in_t  in_data,
  input  fsgs_pkg::fsgs_cmd_t cmd,
  input  logic                out_ready,
  output fsgs_pkg::fsgs_sts_t sts,
  output logic                out_valid,
  output fsgs_pkg::fsgs_out_t out_data
);
  import fsgs_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

  logic [1:0]        mem [DEPTH];
  logic [1:0]        rdata_r;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]  sx_r, sx_nxt;
  logic [ROW_W-1:0]  sy_r, sy_nxt;
  logic [2:0]        cand_r, cand_nxt;
  logic [1:0]        kind_r;
  logic [1:0]        item_func_r;
  logic              item_inside_r;
  logic              out_valid_r, out_valid_nxt;
  fsgs_out_t         out_data_r;

  logic              in_inside;
  logic [ADDR_W-1:0] in_addr, ctr_addr, nb_addr, waddr, raddr;
  logic [COL_W-1:0]  nb_x;
  logic [ROW_W-1:0]  nb_y;
  logic              nb_left, nb_right, nb_down, nb_valid;
  logic [1:0]        wdata;
  logic              we, re;

  assign in_inside = (int'(in_data.col) < GRID_COLS) && (int'(in_data.row) < GRID_ROWS);
  assign in_addr   = {ROW_W'(in_data.row), COL_W'(in_data.col)};
  assign ctr_addr  = {sy_r, sx_r};

  // neighbor order: sand D, DL, DR; water D, DR, DL, R, L
  always_comb begin
    nb_left  = 1'b0;
    nb_right = 1'b0;
    nb_down  = 1'b1;
    case (cand_r)
      3'd0: begin
      end
      3'd1: begin
        if (kind_r == KIND_SAND) nb_left = 1'b1;
        else nb_right = 1'b1;
      end
      3'd2: begin
        if (kind_r == KIND_SAND) nb_right = 1'b1;
        else nb_left = 1'b1;
      end
      3'd3: begin
        nb_right = 1'b1;
        nb_down  = 1'b0;
      end
      default: begin
        nb_left = 1'b1;
        nb_down = 1'b0;
      end
    endcase
  end

  assign nb_x     = nb_left ? (sx_r - 1'b1) : (nb_right ? (sx_r + 1'b1) : sx_r);
  assign nb_y     = nb_down ? (sy_r - 1'b1) : sy_r;
  assign nb_addr  = {nb_y, nb_x};
  assign nb_valid = !(nb_left && (sx_r == '0)) && !(nb_right && (sx_r == COL_LAST));

  always_comb begin
    we    = 1'b0;
    waddr = ctr_addr;
    wdata = KIND_EMPTY;
    case (cmd.wr_sel)
      WR_CLR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
      end
      WR_IO: begin
        we    = in_inside;
        waddr = in_addr;
        wdata = in_data.kind_in;
      end
      WR_TGT: begin
        we    = 1'b1;
        waddr = nb_addr;
        wdata = kind_r;
      end
      WR_CTR: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    re    = 1'b1;
    raddr = ctr_addr;
    case (cmd.rd_sel)
      RD_IO:   raddr = in_addr;
      RD_CTR:  raddr = ctr_addr;
      RD_NB:   raddr = nb_addr;
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_comb begin
    clr_addr_nxt = cmd.clr_step ? (clr_addr_r + 1'b1) : clr_addr_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    if (cmd.adv) begin
      if (sy_r == ROW_LAST) begin
        sy_nxt = '0;
        sx_nxt = (sx_r == COL_LAST) ? '0 : (sx_r + 1'b1);
      end else begin
        sy_nxt = sy_r + 1'b1;
      end
    end
    cand_nxt = cand_r;
    if (cmd.kind_ld) cand_nxt = '0;
    else if (cmd.cand_inc) cand_nxt = cand_r + 1'b1;
    out_valid_nxt = cmd.out_ld || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      cand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      cand_r      <= cand_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kind_ld) kind_r <= rdata_r;
    if (cmd.item_ld) begin
      item_func_r   <= in_data.func;
      item_inside_r <= in_inside;
    end
    if (cmd.out_ld) begin
      if (cmd.out_from_in) begin
        out_data_r.kind_out  <= KIND_EMPTY;
        out_data_r.done_func <= in_data.func;
      end else begin
        out_data_r.kind_out  <= (item_func_r == FUNC_READ && item_inside_r) ?
                                rdata_r : KIND_EMPTY;
        out_data_r.done_func <= item_func_r;
      end
    end
  end

  assign sts.clr_last   = &clr_addr_r;
  assign sts.moves      = (sy_r != '0) && (rdata_r == KIND_SAND || rdata_r == KIND_WATER);
  assign sts.nb_free    = nb_valid && (rdata_r == KIND_EMPTY);
  assign sts.cand_last  = (kind_r == KIND_SAND) ? (cand_r == 3'd2) : (cand_r == 3'd4);
  assign sts.sweep_last = (sx_r == COL_LAST) && (sy_r == ROW_LAST);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/fsgs_ctrl.sv =====
`timescale 1ns / 1ps

module fsgs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_func,
  input  fsgs_pkg::fsgs_sts_t sts,
  output logic                in_ready,
  output fsgs_pkg::fsgs_cmd_t cmd
);
  import fsgs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_FIN,
    ST_RDC,
    ST_CHK,
    ST_RDN,
    ST_EV,
    ST_WC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign accept = in_valid && in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '{wr_sel: WR_NONE, rd_sel: RD_NONE, default: 1'b0};
    case (state_r)
      ST_CLR: begin
        cmd.wr_sel   = WR_CLR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.item_ld = 1'b1;
          case (in_func)
            FUNC_SWEEP: state_nxt = ST_RDC;
            FUNC_READ: begin
              cmd.rd_sel = RD_IO;
              state_nxt  = ST_FIN;
            end
            FUNC_WRITE: begin
              cmd.wr_sel = WR_IO;
              if (sts.out_free) begin
                cmd.out_ld      = 1'b1;
                cmd.out_from_in = 1'b1;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: begin
              if (sts.out_free) begin
                cmd.out_ld      = 1'b1;
                cmd.out_from_in = 1'b1;
              end else begin
                state_nxt = ST_FIN;
              end
            end
          endcase
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_RDC: begin
        cmd.rd_sel = RD_CTR;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        if (sts.moves) begin
          cmd.kind_ld = 1'b1;
          state_nxt   = ST_RDN;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = sts.sweep_last ? ST_FIN : ST_RDC;
        end
      end
      ST_RDN: begin
        cmd.rd_sel = RD_NB;
        state_nxt  = ST_EV;
      end
      ST_EV: begin
        if (sts.nb_free) begin
          cmd.wr_sel = WR_TGT;
          state_nxt  = ST_WC;
        end else if (sts.cand_last) begin
          cmd.adv   = 1'b1;
          state_nxt = sts.sweep_last ? ST_FIN : ST_RDC;
        end else begin
          cmd.cand_inc = 1'b1;
          state_nxt    = ST_RDN;
        end
      end
      ST_WC: begin
        cmd.wr_sel = WR_CTR;
        cmd.adv    = 1'b1;
        state_nxt  = sts.sweep_last ? ST_FIN : ST_RDC;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== design/falling_sand_grid_step.sv =====
// Falling-sand grid: GRID_COLS x GRID_ROWS cells of 2-bit kind in one
// single-port-write, single-port-read memory.
// Input channel in_valid/in_ready/in_data carries one request: write a cell,
// read a cell, or run a full sweep. Output channel out_valid/out_ready/out_data
// returns exactly one result per request, in order.
// A write (or unused code) is done as it is accepted and, if the output register
// is free, loads its result into it; else it waits in ST_FIN. A read loads its
// result after a registered memory read. A sweep visits each cell in column-major
// order through the shared memory port: it reads the cell and, for sand or
// water above row 0, probes neighbors in turn; a move writes the target and
// then clears the cell (2 writes per swap).
// Reset: in_ready stays low for a clearing pass that writes all
// 2^(ROW_W+COL_W) cells (4096 at 64 x 64) empty.
// Stall: one output register holds a finished result; one more request is
// accepted and carried out while it waits, then in_ready stays low until the
// register is taken.
`timescale 1ns / 1ps

module falling_sand_grid_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fsgs_pkg::fsgs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fsgs_pkg::fsgs_out_t out_data
);
  import fsgs_pkg::*;

  fsgs_cmd_t cmd;
  fsgs_sts_t sts;

  fsgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  fsgs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_out_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded over a pending result");

  a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_func != FUNC_READ) |-> out_data.kind_out == KIND_EMPTY)
    else $error("nonzero kind on non-read result");

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel == WR_TGT |=> cmd.wr_sel == WR_CTR)
    else $error("swap target write not followed by center clear");
`endif

endmodule
